FILE: src/bale_pkg.sv
package bale_pkg;

  localparam int Depth = 16;
  localparam int DataWidth = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [4:0] CapReset = 5'd10;

  typedef enum logic [3:0] {
    OP_APPEND  = 4'd0,
    OP_DROP    = 4'd1,
    OP_REM_AT  = 4'd2,
    OP_REM_VAL = 4'd3,
    OP_WRITE   = 4'd4,
    OP_INSERT  = 4'd5,
    OP_FIRST   = 4'd6,
    OP_LAST    = 4'd7,
    OP_READ    = 4'd8,
    OP_REPLACE = 4'd9,
    OP_REVERSE = 4'd10,
    OP_SORT    = 4'd11,
    OP_CLEAR   = 4'd12
  } op_t;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  typedef struct packed {
    logic        we;
    logic [IdxW-1:0] waddr;
    logic [DataWidth-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/bale_if.sv
interface bale_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [7:0]  position;
  logic [15:0] data_value;
  logic [15:0] match_value;
  modport source (output valid, opcode, position, data_value, match_value, input ready);
  modport sink (input valid, opcode, position, data_value, match_value, output ready);
endinterface

interface bale_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink (input valid, result_value, status, entry_count, output ready);
endinterface

interface bale_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: src/bale_ram.sv
module bale_ram (
  input  logic                       clk,
  input  bale_pkg::mem_req_t         req,
  output logic [bale_pkg::DataWidth-1:0] rdata
);
  logic [bale_pkg::DataWidth-1:0] mem [bale_pkg::Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

FILE: src/bale_ctrl.sv
module bale_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  bale_in_if.sink                 in_ch,
  bale_out_if.source              out_ch,
  bale_cfg_if.sink                cfg_ch,
  output bale_pkg::mem_req_t      req,
  input  logic [bale_pkg::DataWidth-1:0] rdata
);
  localparam int IW = bale_pkg::IdxW;
  localparam int CW = bale_pkg::CntW;
  localparam int DW = bale_pkg::DataWidth;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT_DN, S_SHIFT_UP, S_REV_A, S_REV_B, S_REV_W,
    S_SORT_RD, S_SORT_CMP, S_SORT_W, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  bale_pkg::op_t op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0] cap_r, cap_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [DW-1:0] val_r, key_r, tmp_r;
  logic [DW-1:0] val_nxt, key_nxt, tmp_nxt;
  logic [CW-1:0] i_r, j_r, i_nxt, j_nxt;
  logic [15:0] res_r, res_nxt;
  logic [1:0] st_r, st_nxt;
  logic found_r, found_nxt;
  logic first_r, first_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic [IW-1:0] raddr_r, raddr_nxt;

  logic [CW-1:0] cap_eff;
  logic full;
  logic [CW-1:0] pos_ext;

  assign cap_eff = (cap_r > 5'(bale_pkg::Depth)) ? CW'(bale_pkg::Depth) : CW'(cap_r);
  assign full = cnt_r >= cap_eff;
  assign pos_ext = (in_ch.position > 8'(bale_pkg::Depth)) ? CW'(bale_pkg::Depth)
                                                          : CW'(in_ch.position);

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign cfg_ch.ready = rst_n && (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_DONE);
  assign out_ch.result_value = res_r;
  assign out_ch.status = st_r;
  assign out_ch.entry_count = 5'(cnt_r);

  // The RAM request is issued in the cycle it is decided, so read data
  // for an address chosen in one cycle is on rdata in the next.
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    cap_nxt = cap_r;
    pos_nxt = pos_r;
    val_nxt = val_r;
    key_nxt = key_r;
    tmp_nxt = tmp_r;
    i_nxt = i_r;
    j_nxt = j_r;
    res_nxt = res_r;
    st_nxt = st_r;
    found_nxt = found_r;
    first_nxt = first_r;
    hit_nxt = hit_r;
    raddr_nxt = raddr_r;
    req = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_ch.valid && cfg_ch.ready) begin
          cap_nxt = cfg_ch.data;
        end
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = bale_pkg::op_t'(in_ch.opcode);
          val_nxt = in_ch.data_value;
          res_nxt = '0;
          st_nxt = bale_pkg::StOk;
          found_nxt = 1'b0;
          first_nxt = 1'b1;
          state_nxt = S_DONE;
          case (in_ch.opcode)
            bale_pkg::OP_APPEND: begin
              if (full) st_nxt = bale_pkg::StFull;
              else begin
                req.we = 1'b1; req.waddr = IW'(cnt_r);
                req.wdata = in_ch.data_value; cnt_nxt = cnt_r + 1'b1;
              end
            end
            bale_pkg::OP_DROP: begin
              if (cnt_r == '0) st_nxt = bale_pkg::StRange;
              else cnt_nxt = cnt_r - 1'b1;
            end
            bale_pkg::OP_REM_AT: begin
              if (pos_ext >= cnt_r) st_nxt = bale_pkg::StRange;
              else begin
                pos_nxt = pos_ext; i_nxt = pos_ext; state_nxt = S_SHIFT_DN;
                raddr_nxt = IW'(pos_ext + 1'b1);
              end
            end
            bale_pkg::OP_WRITE: begin
              if (pos_ext < cnt_r) begin
                req.we = 1'b1; req.waddr = IW'(pos_ext); req.wdata = in_ch.data_value;
              end else if (full) st_nxt = bale_pkg::StFull;
              else begin
                req.we = 1'b1; req.waddr = IW'(cnt_r);
                req.wdata = in_ch.data_value; cnt_nxt = cnt_r + 1'b1;
              end
            end
            bale_pkg::OP_INSERT: begin
              if (full) st_nxt = bale_pkg::StFull;
              else begin
                pos_nxt = (pos_ext > cnt_r) ? cnt_r : pos_ext;
                i_nxt = cnt_r; state_nxt = S_SHIFT_UP;
                raddr_nxt = IW'(cnt_r - 1'b1);
              end
            end
            bale_pkg::OP_REM_VAL, bale_pkg::OP_FIRST, bale_pkg::OP_LAST: begin
              key_nxt = in_ch.data_value; i_nxt = '0; raddr_nxt = '0;
              state_nxt = S_SCAN;
            end
            bale_pkg::OP_REPLACE: begin
              key_nxt = in_ch.match_value; i_nxt = '0; raddr_nxt = '0;
              state_nxt = S_SCAN;
            end
            bale_pkg::OP_READ: begin
              if (pos_ext >= cnt_r) st_nxt = bale_pkg::StRange;
              else begin
                raddr_nxt = IW'(pos_ext); i_nxt = cnt_r; state_nxt = S_SCAN;
              end
            end
            bale_pkg::OP_REVERSE: begin
              if (cnt_r >= CW'(2)) begin
                i_nxt = '0; j_nxt = cnt_r - 1'b1; raddr_nxt = '0; state_nxt = S_REV_A;
              end
            end
            bale_pkg::OP_SORT: begin
              if (cnt_r >= CW'(2)) begin
                i_nxt = CW'(1); j_nxt = CW'(1); raddr_nxt = IW'(1); state_nxt = S_SORT_RD;
              end
            end
            bale_pkg::OP_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      // One entry enters per cycle; i_r is the index of the entry now on rdata.
      S_SCAN: begin
        if (op_r == bale_pkg::OP_READ) begin
          res_nxt = rdata; state_nxt = S_DONE;
        end else if (i_r >= cnt_r) begin
          state_nxt = S_DONE;
          if (!found_r) st_nxt = bale_pkg::StNotFound;
          else if (op_r == bale_pkg::OP_REM_VAL) begin
            i_nxt = hit_r; raddr_nxt = IW'(hit_r + 1'b1);
            state_nxt = S_SHIFT_DN;
          end else if (op_r == bale_pkg::OP_REPLACE) begin
            req.we = 1'b1; req.waddr = IW'(hit_r); req.wdata = val_r;
          end else res_nxt = 16'(hit_r);
        end else begin
          if (rdata == key_r && (op_r == bale_pkg::OP_LAST || !found_r)) begin
            found_nxt = 1'b1; hit_nxt = i_r;
          end
          i_nxt = i_r + 1'b1;
          raddr_nxt = IW'(i_r + 1'b1);
        end
      end
      // Entry i+1 was read last cycle; write it to i, or once i+1 reaches the count, shrink the count.
      S_SHIFT_DN: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; state_nxt = S_DONE;
        end else begin
          req.we = 1'b1; req.waddr = IW'(i_r); req.wdata = rdata;
          i_nxt = i_r + 1'b1; raddr_nxt = IW'(i_r + 2'd2);
        end
      end
      S_SHIFT_UP: begin
        if (i_r <= pos_r) begin
          req.we = 1'b1; req.waddr = IW'(pos_r); req.wdata = val_r;
          cnt_nxt = cnt_r + 1'b1; state_nxt = S_DONE;
        end else begin
          req.we = 1'b1; req.waddr = IW'(i_r); req.wdata = rdata;
          i_nxt = i_r - 1'b1; raddr_nxt = IW'(i_r - 2'd2);
        end
      end
      S_REV_A: begin
        tmp_nxt = rdata; raddr_nxt = IW'(j_r); state_nxt = S_REV_B;
      end
      S_REV_B: begin
        req.we = 1'b1; req.waddr = IW'(i_r); req.wdata = rdata;
        state_nxt = S_REV_W;
      end
      S_REV_W: begin
        req.we = 1'b1; req.waddr = IW'(j_r); req.wdata = tmp_r;
        if (i_r + 1'b1 >= j_r - 1'b1) state_nxt = S_DONE;
        else begin
          i_nxt = i_r + 1'b1; j_nxt = j_r - 1'b1;
          raddr_nxt = IW'(i_r + 1'b1); state_nxt = S_REV_A;
        end
      end
      // Insertion sort: tmp_r is the key being sunk, j_r its hole.
      S_SORT_RD: begin
        if (first_r) begin
          tmp_nxt = rdata; first_nxt = 1'b0;
          raddr_nxt = IW'(j_r - 1'b1);
        end
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (rdata > tmp_r) begin
          req.we = 1'b1; req.waddr = IW'(j_r); req.wdata = rdata;
          if (j_r == CW'(1)) begin
            j_nxt = '0; state_nxt = S_SORT_W;
          end else begin
            j_nxt = j_r - 1'b1; raddr_nxt = IW'(j_r - 2'd2); state_nxt = S_SORT_RD;
          end
        end else state_nxt = S_SORT_W;
      end
      S_SORT_W: begin
        req.we = 1'b1; req.waddr = IW'(j_r); req.wdata = tmp_r;
        if (i_r + 1'b1 >= cnt_r) state_nxt = S_DONE;
        else begin
          i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1; first_nxt = 1'b1;
          raddr_nxt = IW'(i_r + 1'b1); state_nxt = S_SORT_RD;
        end
      end
      S_DONE: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    req.raddr = raddr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      cap_r <= bale_pkg::CapReset;
      raddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      cap_r <= cap_nxt;
      raddr_r <= raddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    key_r <= key_nxt;
    tmp_r <= tmp_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    res_r <= res_nxt;
    st_r <= st_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    hit_r <= hit_nxt;
  end
endmodule

FILE: src/bounded_array_list_engine.sv
// Bounded array list engine: a packed list of up to 16 values of 16 bits.
// Commands enter on the in_ channel (opcode, position, data_value,
// match_value); every command yields exactly one transaction on the out_
// channel with result_value, status and entry_count after the command.
// The cfg_ channel writes capacity_in_use; it is taken only while idle.
// One command is handled at a time, through a RAM with one write and one
// read port and a registered read. Append, drop, write, clear and unused
// codes go straight to the result; read waits for its RAM read; first
// index, last index, replace, remove at, insert, remove value, reverse
// and sort loop through the RAM, reading, comparing and writing back
// entries. A new command is accepted the cycle after the result is taken.
// The result holds while out_ch.ready is low and no input is accepted then.
// Reset clears the count and sets the capacity to 10; RAM contents are
// left as they are, and entries beyond the count are never used.
module bounded_array_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  bale_in_if.sink     in_ch,
  bale_out_if.source  out_ch,
  bale_cfg_if.sink    cfg_ch
);
  bale_pkg::mem_req_t req;
  logic [bale_pkg::DataWidth-1:0] rdata;

  bale_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .req(req), .rdata(rdata)
  );

  bale_ram u_ram (.clk(clk), .req(req), .rdata(rdata));
endmodule
